FILE: design/plle_pkg.sv
// ----------------------------------------------------------------------------
// plle_pkg
// Opcodes, status codes and sequencer states of the linked list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plle_pkg;

  localparam logic [2:0] OP_INS_FIRST = 3'd0;
  localparam logic [2:0] OP_INS_LAST  = 3'd1;
  localparam logic [2:0] OP_INS_AT    = 3'd2;
  localparam logic [2:0] OP_DEL_FIRST = 3'd3;
  localparam logic [2:0] OP_DEL_LAST  = 3'd4;
  localparam logic [2:0] OP_DEL_AT    = 3'd5;
  localparam logic [2:0] OP_DUMP      = 3'd6;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_PAST_END = 2'd3;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_READ   = 8'b0000_0010,
    S_STEP   = 8'b0000_0100,
    S_FIX    = 8'b0000_1000,
    S_FRONT  = 8'b0001_0000,
    S_UNLINK = 8'b0010_0000,
    S_DUMP   = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_e;

endpackage

`default_nettype wire

FILE: design/plle_ram.sv
// ----------------------------------------------------------------------------
// plle_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: design/plle_free_pick.sv
// ----------------------------------------------------------------------------
// plle_free_pick
// Registered priority encoder: lowest free slot of the pool bitmap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plle_free_pick #(
  parameter int CAPACITY = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [CAPACITY-1:0]         free_i,
  output logic      [$clog2(CAPACITY)-1:0] slot_o
);

  localparam int SLOT_W = $clog2(CAPACITY);

  logic [SLOT_W-1:0] slot_d;

  always_comb begin
    slot_d = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_i[i]) begin
        slot_d = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_o <= '0;
    end else begin
      slot_o <= slot_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/positional_linked_list_engine.sv
// ----------------------------------------------------------------------------
// positional_linked_list_engine
// Bounded singly linked list in a node pool, walked one link per cycle unless a dump is held by the output stall.
// ----------------------------------------------------------------------------
// Throughput: one operation at a time; the link walk reads one node per cycle
// from the link RAM (a dump only while the output is not stalled), so the walk
// length sets the rate.
// Reset: list empty, head zero, every slot free; node RAMs are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module positional_linked_list_engine #(
  parameter int CAPACITY   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [31:0] value_i,
  input  wire logic [5:0]  position_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [31:0]      item_value_o,
  output logic [4:0]       item_index_o,
  output logic             last_item_o,
  output logic [5:0]       element_count_o
);

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int LEN_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (LEN_W > 6) ? LEN_W : 6;

  plle_pkg::state_e state_q, state_d;

  logic [CAPACITY-1:0] free_q, free_d;
  logic [SLOT_W-1:0]   head_q, head_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [SLOT_W-1:0]   cur_q, cur_d;
  logic [SLOT_W-1:0]   prev_q, prev_d;
  logic [LEN_W-1:0]    cnt_q, cnt_d;
  logic [LEN_W-1:0]    idx_q, idx_d;
  logic                ins_q, ins_d;
  logic                dump_q, dump_d;
  logic                del_head_q, del_head_d;
  logic [1:0]          res_q, res_d;
  logic [31:0]         val_q, val_d;

  logic                out_valid_q, out_valid_d;
  logic [1:0]          out_status_q, out_status_d;
  logic [31:0]         out_value_q, out_value_d;
  logic [4:0]          out_index_q, out_index_d;
  logic                out_last_q, out_last_d;
  logic [5:0]          out_count_q, out_count_d;

  logic [SLOT_W-1:0]     free_slot;
  logic [SLOT_W-1:0]     rd_addr;
  logic [SLOT_W-1:0]     link_rdata;
  logic [VALUE_BITS-1:0] val_rdata;
  logic                  link_we;
  logic [SLOT_W-1:0]     link_waddr;
  logic [SLOT_W-1:0]     link_wdata;
  logic                  val_we;
  logic [VALUE_BITS-1:0] val_wdata;

  logic              can_load;
  logic              full;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  len_ext;
  logic [CMP_W-1:0]  k_ins_wide;
  logic [LEN_W-1:0]  k_ins;
  logic [LEN_W-1:0]  len_m1;
  logic              dump_last;
  logic [63:0]       val_in_ext;
  logic [63:0]       val_out_ext;
  logic [6:0]        idx_ext;
  logic [6:0]        len_out_ext;
  logic [CAPACITY-1:0] cur_bit;
  logic [CAPACITY-1:0] slot_bit;

  plle_free_pick #(
    .CAPACITY(CAPACITY)
  ) u_free_pick (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .free_i(free_q),
    .slot_o(free_slot)
  );

  plle_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(CAPACITY)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .raddr_i(rd_addr),
    .rdata_o(link_rdata)
  );

  plle_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(CAPACITY)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(free_slot),
    .wdata_i(val_wdata),
    .raddr_i(rd_addr),
    .rdata_o(val_rdata)
  );

  assign in_stall_o      = (state_q != plle_pkg::S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign item_value_o    = out_value_q;
  assign item_index_o    = out_index_q;
  assign last_item_o     = out_last_q;
  assign element_count_o = out_count_q;

  assign can_load    = !out_valid_q || !out_stall_i;
  assign full        = (len_q == LEN_W'(CAPACITY));
  assign pos_ext     = CMP_W'(position_i);
  assign len_ext     = CMP_W'(len_q);
  assign k_ins_wide  = (pos_ext > len_ext) ? len_ext : pos_ext;
  assign k_ins       = k_ins_wide[LEN_W-1:0];
  assign len_m1      = len_q - LEN_W'(1);
  assign dump_last   = (idx_q == len_m1);
  assign val_in_ext  = 64'(signed'(val_q));
  assign val_wdata   = val_in_ext[VALUE_BITS-1:0];
  assign val_out_ext = 64'(val_rdata);
  assign idx_ext     = 7'(idx_q);
  assign len_out_ext = 7'(len_q);
  assign cur_bit     = CAPACITY'(1) << cur_q;
  assign slot_bit    = CAPACITY'(1) << free_slot;

  // walk and dump advance straight from the link just read
  assign rd_addr = ((state_q == plle_pkg::S_STEP) ||
                    ((state_q == plle_pkg::S_DUMP) && can_load)) ? link_rdata : cur_q;

  always_comb begin
    state_d    = state_q;
    free_d     = free_q;
    head_d     = head_q;
    len_d      = len_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    ins_d      = ins_q;
    dump_d     = dump_q;
    del_head_d = del_head_q;
    res_d      = res_q;
    val_d      = val_q;
    link_we    = 1'b0;
    link_waddr = cur_q;
    link_wdata = link_rdata;
    val_we     = 1'b0;

    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_index_d  = out_index_q;
    out_last_d   = out_last_q;
    out_count_d  = out_count_q;

    unique case (state_q)
      plle_pkg::S_IDLE: begin
        if (in_valid_i) begin
          val_d      = value_i;
          res_d      = plle_pkg::ST_DONE;
          cur_d      = head_q;
          idx_d      = '0;
          ins_d      = 1'b0;
          dump_d     = 1'b0;
          del_head_d = 1'b0;
          state_d    = plle_pkg::S_RESULT;
          unique case (opcode_i) inside
            plle_pkg::OP_INS_FIRST, plle_pkg::OP_INS_LAST, plle_pkg::OP_INS_AT: begin
              if (full) begin
                res_d = plle_pkg::ST_FULL;
              end else begin
                ins_d = 1'b1;
                if (opcode_i == plle_pkg::OP_INS_FIRST) begin
                  cnt_d = '0;
                end else if (opcode_i == plle_pkg::OP_INS_LAST) begin
                  cnt_d = len_q;
                end else begin
                  cnt_d = k_ins;
                end
                if (cnt_d == '0) begin
                  state_d = plle_pkg::S_FRONT;
                end else begin
                  cnt_d   = cnt_d - LEN_W'(1);
                  state_d = plle_pkg::S_READ;
                end
              end
            end
            plle_pkg::OP_DEL_FIRST, plle_pkg::OP_DEL_LAST, plle_pkg::OP_DEL_AT: begin
              if (len_q == '0) begin
                res_d = plle_pkg::ST_EMPTY;
              end else if ((opcode_i == plle_pkg::OP_DEL_AT) && (pos_ext >= len_ext)) begin
                res_d = plle_pkg::ST_PAST_END;
              end else begin
                if (opcode_i == plle_pkg::OP_DEL_FIRST) begin
                  cnt_d = '0;
                end else if (opcode_i == plle_pkg::OP_DEL_LAST) begin
                  cnt_d = len_m1;
                end else begin
                  cnt_d = pos_ext[LEN_W-1:0];
                end
                if (cnt_d == '0) begin
                  del_head_d = 1'b1;
                end else begin
                  cnt_d = cnt_d - LEN_W'(1);
                end
                state_d = plle_pkg::S_READ;
              end
            end
            plle_pkg::OP_DUMP: begin
              if (len_q == '0) begin
                res_d = plle_pkg::ST_EMPTY;
              end else begin
                dump_d  = 1'b1;
                state_d = plle_pkg::S_READ;
              end
            end
            default: begin
              res_d = plle_pkg::ST_DONE;
            end
          endcase
        end
      end

      plle_pkg::S_READ: begin
        state_d = dump_q ? plle_pkg::S_DUMP : plle_pkg::S_STEP;
      end

      plle_pkg::S_STEP: begin
        if (cnt_q != '0) begin
          cur_d = link_rdata;
          cnt_d = cnt_q - LEN_W'(1);
        end else if (ins_q) begin
          // new node takes over the successor of the predecessor node
          link_we    = 1'b1;
          link_waddr = free_slot;
          link_wdata = link_rdata;
          val_we     = 1'b1;
          state_d    = plle_pkg::S_FIX;
        end else if (del_head_q) begin
          head_d  = link_rdata;
          free_d  = free_q | cur_bit;
          len_d   = len_q - LEN_W'(1);
          state_d = plle_pkg::S_RESULT;
        end else begin
          prev_d  = cur_q;
          cur_d   = link_rdata;
          state_d = plle_pkg::S_UNLINK;
        end
      end

      plle_pkg::S_FIX: begin
        link_we    = 1'b1;
        link_waddr = cur_q;
        link_wdata = free_slot;
        free_d     = free_q & ~slot_bit;
        len_d      = len_q + LEN_W'(1);
        state_d    = plle_pkg::S_RESULT;
      end

      plle_pkg::S_FRONT: begin
        link_we    = 1'b1;
        link_waddr = free_slot;
        link_wdata = (len_q == '0) ? '0 : head_q;
        val_we     = 1'b1;
        head_d     = free_slot;
        free_d     = free_q & ~slot_bit;
        len_d      = len_q + LEN_W'(1);
        state_d    = plle_pkg::S_RESULT;
      end

      plle_pkg::S_UNLINK: begin
        // link_rdata holds the successor of the removed node
        link_we    = 1'b1;
        link_waddr = prev_q;
        link_wdata = link_rdata;
        free_d     = free_q | cur_bit;
        len_d      = len_q - LEN_W'(1);
        state_d    = plle_pkg::S_RESULT;
      end

      plle_pkg::S_DUMP: begin
        if (can_load) begin
          out_valid_d  = 1'b1;
          out_status_d = plle_pkg::ST_DONE;
          out_value_d  = val_out_ext[31:0];
          out_index_d  = idx_ext[4:0];
          out_last_d   = dump_last;
          out_count_d  = len_out_ext[5:0];
          if (dump_last) begin
            state_d = plle_pkg::S_IDLE;
          end else begin
            cur_d = link_rdata;
            idx_d = idx_q + LEN_W'(1);
          end
        end
      end

      plle_pkg::S_RESULT: begin
        if (can_load) begin
          out_valid_d  = 1'b1;
          out_status_d = res_q;
          out_value_d  = '0;
          out_index_d  = '0;
          out_last_d   = 1'b1;
          out_count_d  = len_out_ext[5:0];
          state_d      = plle_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = plle_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plle_pkg::S_IDLE;
      free_q      <= '1;
      head_q      <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
      ins_q       <= 1'b0;
      dump_q      <= 1'b0;
      del_head_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_q      <= free_d;
      head_q      <= head_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      ins_q       <= ins_d;
      dump_q      <= dump_d;
      del_head_q  <= del_head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    res_q        <= res_d;
    val_q        <= val_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_index_q  <= out_index_d;
    out_last_q   <= out_last_d;
    out_count_q  <= out_count_d;
  end

endmodule

`default_nettype wire
